// ===== hw/rtl/bale_pkg.sv =====
`timescale 1ns / 1ps

package bale_pkg;

    // Fixed field widths of the request and result transactions
    localparam int KIND_W   = 4;
    localparam int LOC_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 7;
    localparam int COUNT_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT_AT     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND        = 4'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_AT     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_READ          = 4'd3;
    localparam logic [KIND_W-1:0] KIND_OVERWRITE     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR         = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SEARCH        = 4'd6;
    localparam logic [KIND_W-1:0] KIND_INSERT_UNIQUE = 4'd7;
    localparam logic [KIND_W-1:0] KIND_REMOVE_VALUE  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_COMPARE_AT    = 4'd9;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd5;

    // Cell operations
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD       = 2'd0;
    localparam cell_op_t CELL_WRITE      = 2'd1;
    localparam cell_op_t CELL_SHIFT_UP   = 2'd2;
    localparam cell_op_t CELL_SHIFT_DOWN = 2'd3;

    // Broadcast control to the row of cells
    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/bounded_array_list_engine_core.sv =====
`timescale 1ns / 1ps

// Ordered list of up to DEPTH values held in a row of cells, one entry per cell,
// packed from index 0. Each request transaction gives exactly one result
// transaction. When a request is taken, all cells compare against the value and
// the addressed entry is latched; the first match is then encoded into a register,
// and after that the shift, write and result are applied. A new request is taken
// only once the previous one has been applied, so the engine cannot take a request
// while one is in flight. Insert-at and removals shift the entries from the
// affected index upward by one cell. The result register lets the next request
// in while a result still waits. Capacity writes are taken at any time and
// should be made while no request is in flight. Entries need no clearing after
// reset; only the entry count is cleared.
module bounded_array_list_engine_core #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Capacity register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bale_pkg::CAP_W-1:0]         cfg_data,
    // Request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bale_pkg::KIND_W-1:0]        s_kind,
    input  logic [bale_pkg::LOC_W-1:0]         s_location,
    input  logic [bale_pkg::VAL_W-1:0]         s_value,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bale_pkg::STATUS_W-1:0]      m_status,
    output logic [bale_pkg::VAL_W-1:0]         m_data,
    output logic [bale_pkg::LOC_W-1:0]         m_found_index,
    output logic                               m_match,
    output logic [bale_pkg::COUNT_W-1:0]       m_count,
    output logic                               m_is_empty,
    output logic                               m_is_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = (CNT_W > bale_pkg::LOC_W) ? CNT_W : bale_pkg::LOC_W;
    localparam int CMP_W = (CNT_W > bale_pkg::CAP_W) ? CNT_W : bale_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIND  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [bale_pkg::KIND_W-1:0]     kind_reg;
    logic [bale_pkg::LOC_W-1:0]      loc_reg;
    logic [VALUE_WIDTH-1:0]          key_reg;
    logic [VALUE_WIDTH-1:0]          rd_data_reg;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [bale_pkg::CAP_W-1:0]      cap_reg;

    logic                            m_valid_reg, m_valid_next;
    logic [bale_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [VALUE_WIDTH-1:0]          data_reg, data_next;
    logic [POS_W-1:0]                fidx_reg, fidx_next;
    logic                            match_reg, match_next;
    logic [CNT_W-1:0]                ocount_reg;
    logic                            empty_reg, full_reg;

    logic                            accept;
    logic                            commit;
    logic [VALUE_WIDTH-1:0]          key;
    logic [POS_W-1:0]                pos;
    logic [POS_W-1:0]                apply_pos;
    logic [POS_W-1:0]                loc_ext;
    logic [POS_W-1:0]                count_pos;
    bale_pkg::cell_op_t              apply_op;
    bale_pkg::cell_ctrl_t            ctrl;
    logic [CMP_W-1:0]                limit;
    logic                            list_full;

    logic [VALUE_WIDTH-1:0]          cell_data [DEPTH];
    logic [VALUE_WIDTH-1:0]          cell_sel  [DEPTH];
    logic [DEPTH-1:0]                match_vec;
    logic [VALUE_WIDTH-1:0]          rd_data;
    logic [POS_W-1:0]                found_idx;
    logic                            hit;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign commit    = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);

    // Key and position broadcast: request fields while taking, latched key and decoded position after
    assign key       = (state_reg == S_IDLE) ? VALUE_WIDTH'(s_value) : key_reg;
    assign pos       = (state_reg == S_IDLE) ? POS_W'(s_location) : apply_pos;
    assign loc_ext   = POS_W'(loc_reg);
    assign count_pos = POS_W'(count_reg);

    assign ctrl.op     = commit ? apply_op : bale_pkg::CELL_HOLD;
    assign ctrl.cmp_en = accept;

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_d;
        logic [VALUE_WIDTH-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = key;
        end else begin : g_mid
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_inner
            assign right_d = cell_data[i+1];
        end
        bale_cell #(
            .IDX         (i),
            .POS_W       (POS_W),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos),
            .count      (count_pos),
            .key        (key),
            .left_data  (left_d),
            .right_data (right_d),
            .data_q     (cell_data[i]),
            .sel_data   (cell_sel[i]),
            .match_q    (match_vec[i])
        );
    end

    // Addressed entry, gathered from the row
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_data = rd_data | cell_sel[i];
        end
    end

    bale_find #(
        .DEPTH (DEPTH),
        .POS_W (POS_W)
    ) u_find (
        .aclk      (aclk),
        .match_vec (match_vec),
        .found_idx (found_idx),
        .hit       (hit)
    );

    // Effective capacity and fullness before the request
    assign limit     = (CMP_W'(cap_reg) > DEPTH_C) ? DEPTH_C : CMP_W'(cap_reg);
    assign list_full = CMP_W'(count_reg) >= limit;

    // Request decode for the apply step
    always_comb begin
        status_next = bale_pkg::STAT_OK;
        data_next   = '0;
        fidx_next   = '0;
        match_next  = 1'b0;
        count_next  = count_reg;
        apply_op    = bale_pkg::CELL_HOLD;
        apply_pos   = loc_ext;
        case (kind_reg)
            bale_pkg::KIND_INSERT_AT: begin
                if (loc_ext > count_pos) begin
                    status_next = bale_pkg::STAT_RANGE;
                end else if (list_full) begin
                    status_next = bale_pkg::STAT_FULL;
                end else begin
                    apply_op   = bale_pkg::CELL_SHIFT_UP;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bale_pkg::KIND_APPEND: begin
                if (list_full) begin
                    status_next = bale_pkg::STAT_FULL;
                end else begin
                    apply_op   = bale_pkg::CELL_WRITE;
                    apply_pos  = count_pos;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bale_pkg::KIND_REMOVE_AT: begin
                if (loc_ext >= count_pos) begin
                    status_next = bale_pkg::STAT_RANGE;
                end else begin
                    apply_op   = bale_pkg::CELL_SHIFT_DOWN;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            bale_pkg::KIND_READ: begin
                if (loc_ext >= count_pos) status_next = bale_pkg::STAT_RANGE;
                else data_next = rd_data_reg;
            end
            bale_pkg::KIND_OVERWRITE: begin
                if (loc_ext >= count_pos) status_next = bale_pkg::STAT_RANGE;
                else apply_op = bale_pkg::CELL_WRITE;
            end
            bale_pkg::KIND_CLEAR: begin
                count_next = '0;
            end
            bale_pkg::KIND_SEARCH: begin
                if (hit) begin
                    fidx_next  = found_idx;
                    match_next = 1'b1;
                end else begin
                    status_next = bale_pkg::STAT_NOTFOUND;
                end
            end
            bale_pkg::KIND_INSERT_UNIQUE: begin
                if (list_full) begin
                    status_next = bale_pkg::STAT_FULL;
                end else if (hit) begin
                    status_next = bale_pkg::STAT_DUP;
                end else begin
                    apply_op   = bale_pkg::CELL_WRITE;
                    apply_pos  = count_pos;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            bale_pkg::KIND_REMOVE_VALUE: begin
                if (count_reg == '0) begin
                    status_next = bale_pkg::STAT_EMPTY;
                end else if (hit) begin
                    apply_op   = bale_pkg::CELL_SHIFT_DOWN;
                    apply_pos  = found_idx;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = bale_pkg::STAT_NOTFOUND;
                end
            end
            bale_pkg::KIND_COMPARE_AT: begin
                if (loc_ext >= count_pos) status_next = bale_pkg::STAT_RANGE;
                else match_next = (rd_data_reg == key_reg);
            end
            default: begin
                status_next = bale_pkg::STAT_OK;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_FIND;
            S_FIND:  state_next = S_APPLY;
            S_APPLY: if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid_next = commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cap_reg     <= bale_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) count_reg <= count_next;
            if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
        end
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg    <= s_kind;
            loc_reg     <= s_location;
            key_reg     <= VALUE_WIDTH'(s_value);
            rd_data_reg <= rd_data;
        end
        if (commit) begin
            status_reg <= status_next;
            data_reg   <= data_next;
            fidx_reg   <= fidx_next;
            match_reg  <= match_next;
            ocount_reg <= count_next;
            empty_reg  <= (count_next == '0);
            full_reg   <= CMP_W'(count_next) >= limit;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_data        = bale_pkg::VAL_W'(data_reg);
    assign m_found_index = bale_pkg::LOC_W'(fidx_reg);
    assign m_match       = match_reg;
    assign m_count       = bale_pkg::COUNT_W'(ocount_reg);
    assign m_is_empty    = empty_reg;
    assign m_is_full     = full_reg;

endmodule

// ===== hw/rtl/bale_cell.sv =====
`timescale 1ns / 1ps

module bale_cell #(
    parameter int IDX         = 0,
    parameter int POS_W       = 7,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  bale_pkg::cell_ctrl_t   ctrl,
    input  logic [POS_W-1:0]       pos,
    input  logic [POS_W-1:0]       count,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic [VALUE_WIDTH-1:0] left_data,
    input  logic [VALUE_WIDTH-1:0] right_data,
    output logic [VALUE_WIDTH-1:0] data_q,
    output logic [VALUE_WIDTH-1:0] sel_data,
    output logic                   match_q
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;
    logic                   match_reg;
    logic                   at_pos;
    logic                   above_pos;

    assign at_pos    = (MY_IDX == pos);
    assign above_pos = (MY_IDX > pos);

    // Entry update: hold, write in place, or take a neighbour's entry
    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            bale_pkg::CELL_WRITE: begin
                if (at_pos) data_next = key;
            end
            bale_pkg::CELL_SHIFT_UP: begin
                if (above_pos) data_next = left_data;
                else if (at_pos) data_next = key;
            end
            bale_pkg::CELL_SHIFT_DOWN: begin
                if (above_pos || at_pos) data_next = right_data;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        // Equality against the key, only for occupied slots
        if (ctrl.cmp_en) match_reg <= (data_reg == key) && (MY_IDX < count);
    end

    assign data_q   = data_reg;
    assign match_q  = match_reg;
    assign sel_data = at_pos ? data_reg : '0;

endmodule

// ===== hw/rtl/bale_find.sv =====
`timescale 1ns / 1ps

module bale_find #(
    parameter int DEPTH = 64,
    parameter int POS_W = 7
) (
    input  logic             aclk,
    input  logic [DEPTH-1:0] match_vec,
    output logic [POS_W-1:0] found_idx,
    output logic             hit
);

    logic [DEPTH-1:0] lowest;
    logic [POS_W-1:0] idx_next;
    logic [POS_W-1:0] idx_reg;
    logic             hit_reg;

    // Isolate the lowest set match bit
    assign lowest = match_vec & (~match_vec + DEPTH'(1));

    // One-hot to binary
    always_comb begin
        idx_next = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lowest[i]) idx_next = idx_next | POS_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        hit_reg <= |match_vec;
    end

    assign found_idx = idx_reg;
    assign hit       = hit_reg;

endmodule
